// ----- hw/rtl/grsl_pkg.sv -----
// ----------------------------------------------------------------------------
// Glyph run strip layout package
// Shared types, constants and glyph mapping tables.
// ----------------------------------------------------------------------------
package grsl_pkg;

  localparam logic [8:0] STRIP_WIDTH = 9'd256;
  localparam logic [6:0] MAX_UPLOADS = 7'd64;

  localparam logic [4:0] V_END_VALUE   = 5'd20;
  localparam logic [7:0] CTRL_LIMIT    = 8'h20;
  localparam logic [7:0] DOLLAR_CODE   = 8'h24;
  localparam logic [7:0] DOLLAR_GLYPH  = 8'h89;
  localparam logic [3:0] DEFAULT_ADV   = 4'd9;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_GLYPH = 2'd1,
    CMD_END   = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_UPLOAD = 2'd0,
    KIND_FLUSH  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic {
    REG_SLOT_NUMBER = 1'b0,
    REG_HEIGHT_STEP = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic        last;
    logic        error;
    logic [7:0]  run_height;
    logic [8:0]  run_width;
    logic [4:0]  v_end;
    logic [9:0]  u_end;
    logic [15:0] pos_y;
    logic [15:0] pos_x;
    logic [7:0]  slot_out;
    logic [12:0] font_offset;
    logic [8:0]  cell_x;
    kind_t       kind;
  } result_t;

  // advance in pixels for a printable byte
  function automatic logic [3:0] glyph_width(input logic [7:0] c);
    logic [3:0] w;
    case (c) inside
      8'h20, 8'h2E, 8'h60:                                    w = 4'd5;
      8'h21, 8'h27, 8'h49, 8'h69, 8'h6C, 8'hA1:               w = 4'd4;
      8'h28, 8'h29, 8'h2F, 8'h3B, 8'h5B, 8'h5C,
      8'h5D, 8'h66, 8'h84, 8'h93, 8'h94:                      w = 4'd8;
      8'h2C, 8'h6A, 8'h82, 8'h91, 8'h92, 8'hA6:               w = 4'd6;
      8'h3A, 8'h4A:                                           w = 4'd7;
      8'h4D, 8'h57, 8'h6D, 8'h77:                             w = 4'd12;
      default:                                                w = DEFAULT_ADV;
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/glyph_run_strip_layout_unit.sv -----
// ----------------------------------------------------------------------------
// Glyph run strip layout unit
// Top level: request stream in, upload/flush/error results out.
// ----------------------------------------------------------------------------
// Takes one request per cycle (begin, glyph byte or end) and emits zero, one
// or two results: an upload per glyph, a flush when the strip fills or the
// run ends, or an error report once a strip holds too many uploads. Results
// go through a three-entry output queue, so a request is taken every cycle
// while the downstream side keeps up; the queue, not the layout logic, sets
// when s_tready drops. Each result is registered into the queue when its
// request is taken. A glyph that fills the strip yields two results, an upload
// and a flush.
module glyph_run_strip_layout_unit import grsl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // glyph_code[7:0], start_x[23:8], start_y[39:24]
  input  logic [1:0]  s_tuser,   // cmd[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // cell_x[8:0], font_offset[21:9], slot_out[29:22],
                                 // pos_x[45:30], pos_y[61:46], u_end[71:62],
                                 // v_end[76:72], run_width[85:77],
                                 // run_height[93:86], error[94], zero[95]
  output logic [1:0]  m_tuser,   // kind[1:0]
  output logic        m_tlast,
  input  logic        cfg_wen,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] slot_number;
  logic [7:0] height_step;

  result_t    res0, res1;
  logic [1:0] res_n;
  logic       accept;
  logic       pop;

  result_t    q [0:2];
  result_t    q_next [0:2];
  logic [1:0] count, count_next;
  logic [1:0] base;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_number <= 8'd1;
      height_step <= 8'd20;
    end else if (cfg_wen) begin
      case (reg_index_t'(cfg_index))
        REG_SLOT_NUMBER: slot_number <= cfg_data;
        REG_HEIGHT_STEP: height_step <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign m_tvalid = (count != 2'd0);
  assign pop      = m_tvalid & m_tready;
  assign s_tready = (count <= 2'd1) || (count == 2'd2 && m_tready);
  assign accept   = s_tvalid & s_tready;

  grsl_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .cmd         (cmd_t'(s_tuser)),
    .glyph_code  (s_tdata[7:0]),
    .start_x     (s_tdata[23:8]),
    .start_y     (s_tdata[39:24]),
    .slot_number (slot_number),
    .height_step (height_step),
    .res0        (res0),
    .res1        (res1),
    .res_n       (res_n)
  );

  assign base = count - {1'b0, pop};

  always_comb begin
    q_next = q;
    if (pop) begin
      q_next[0] = q[1];
      q_next[1] = q[2];
    end
    for (int i = 0; i < 3; i++) begin
      if (accept && res_n != 2'd0 && 2'(i) == base) begin
        q_next[i] = res0;
      end
      if (accept && res_n == 2'd2 && 2'(i) == base + 2'd1) begin
        q_next[i] = res1;
      end
    end
    count_next = base + (accept ? res_n : 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      q[i] <= q_next[i];
    end
  end

  assign m_tuser = q[0].kind;
  assign m_tlast = q[0].last;
  assign m_tdata = {1'b0, q[0].error, q[0].run_height, q[0].run_width, q[0].v_end,
                    q[0].u_end, q[0].pos_y, q[0].pos_x, q[0].slot_out,
                    q[0].font_offset, q[0].cell_x};

  a_full_stalls: assert property (@(posedge clk) disable iff (rst)
    count == 2'd3 |-> !s_tready) else $error("request taken with full queue");

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_FLUSH |-> m_tlast) else $error("flush not last");

  a_error_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_ERROR |-> m_tlast) else $error("error not last");

  a_upload_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_UPLOAD && !m_tlast |-> count >= 2'd2)
    else $error("upload without its flush queued");

endmodule

// ----- hw/rtl/grsl_core.sv -----
// ----------------------------------------------------------------------------
// Glyph run strip layout core
// Run state and result generation for one accepted request per cycle.
// ----------------------------------------------------------------------------
module grsl_core import grsl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  cmd_t        cmd,
  input  logic [7:0]  glyph_code,
  input  logic [15:0] start_x,
  input  logic [15:0] start_y,
  input  logic [7:0]  slot_number,
  input  logic [7:0]  height_step,
  output result_t     res0,
  output result_t     res1,
  output logic [1:0]  res_n
);

  logic [8:0]  strip_cursor, strip_cursor_next;
  logic [15:0] screen_x, screen_x_next;
  logic [15:0] screen_y, screen_y_next;
  logic [6:0]  uploads, uploads_next;
  logic        fault_flag, fault_flag_next;

  logic        printable;
  logic [3:0]  adv;
  logic [7:0]  glyph;
  logic [12:0] offset;
  logic [8:0]  cursor_sum;
  logic        wrap;

  function automatic result_t make_flush(input logic [8:0] cur, input logic [15:0] sx,
                                         input logic [15:0] sy, input logic [7:0] slot,
                                         input logic [7:0] height);
    result_t r;
    r             = '0;
    r.kind        = KIND_FLUSH;
    r.slot_out    = slot;
    r.pos_x       = sx;
    r.pos_y       = sy;
    r.u_end       = {1'b0, cur} + 10'd1;
    r.v_end       = V_END_VALUE;
    r.run_width   = cur;
    r.run_height  = height;
    return r;
  endfunction

  function automatic result_t make_error();
    result_t r;
    r       = '0;
    r.kind  = KIND_ERROR;
    r.error = 1'b1;
    return r;
  endfunction

  assign printable  = (glyph_code >= CTRL_LIMIT);
  assign adv        = printable ? glyph_width(glyph_code) : 4'd0;
  assign glyph      = !printable ? 8'd0 :
                      (glyph_code == DOLLAR_CODE) ? DOLLAR_GLYPH : glyph_code - CTRL_LIMIT;
  // times 30 as 32x - 2x
  assign offset     = ({glyph, 5'd0}) - ({4'd0, glyph, 1'b0});
  assign cursor_sum = strip_cursor + {5'd0, adv};
  assign wrap       = (cursor_sum >= STRIP_WIDTH);

  always_comb begin
    strip_cursor_next = strip_cursor;
    screen_x_next     = screen_x;
    screen_y_next     = screen_y;
    uploads_next      = uploads;
    fault_flag_next   = fault_flag;
    res0              = '0;
    res1              = '0;
    res_n             = 2'd0;
    case (cmd)
      CMD_BEGIN: begin
        screen_x_next     = start_x;
        screen_y_next     = start_y;
        strip_cursor_next = '0;
        uploads_next      = '0;
        fault_flag_next   = 1'b0;
      end
      CMD_GLYPH, CMD_END: begin
        if (fault_flag) begin
          res0      = make_error();
          res0.last = 1'b1;
          res_n     = 2'd1;
        end else if (cmd == CMD_END) begin
          res0              = make_flush(strip_cursor, screen_x, screen_y,
                                         slot_number, height_step);
          res0.last         = 1'b1;
          res_n             = 2'd1;
          screen_x_next     = screen_x + {7'd0, strip_cursor};
          strip_cursor_next = '0;
          uploads_next      = '0;
        end else if (uploads >= MAX_UPLOADS) begin
          fault_flag_next = 1'b1;
          res0            = make_error();
          res0.last       = 1'b1;
          res_n           = 2'd1;
        end else begin
          res0.kind        = KIND_UPLOAD;
          res0.cell_x      = strip_cursor;
          res0.font_offset = offset;
          if (wrap) begin
            res1              = make_flush(cursor_sum, screen_x, screen_y,
                                           slot_number, height_step);
            res1.last         = 1'b1;
            res_n             = 2'd2;
            screen_x_next     = screen_x + {7'd0, cursor_sum};
            strip_cursor_next = '0;
            uploads_next      = '0;
          end else begin
            res0.last         = 1'b1;
            res_n             = 2'd1;
            strip_cursor_next = cursor_sum;
            uploads_next      = uploads + 7'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_cursor <= '0;
      screen_x     <= '0;
      screen_y     <= '0;
      uploads      <= '0;
      fault_flag   <= 1'b0;
    end else if (accept) begin
      strip_cursor <= strip_cursor_next;
      screen_x     <= screen_x_next;
      screen_y     <= screen_y_next;
      uploads      <= uploads_next;
      fault_flag   <= fault_flag_next;
    end
  end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// Glyph run strip layout unit testbench
// Drives begin/glyph/end requests into the layout unit, predicts every upload,
// flush and overflow report in a behavioral model kept in this file, and
// checks each result field by field. A short directed table comes first, then
// randomized runs under several slot/height settings with bursty requests
// and a stalling result consumer.
// ----------------------------------------------------------------------------
module testbench;
  import grsl_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // glyph_code[7:0], start_x[23:8], start_y[39:24]
  logic [1:0]  s_tuser;   // cmd[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [95:0] m_tdata;   // cell_x[8:0], font_offset[21:9], slot_out[29:22],
                          // pos_x[45:30], pos_y[61:46], u_end[71:62],
                          // v_end[76:72], run_width[85:77],
                          // run_height[93:86], error[94], zero[95]
  logic [1:0]  m_tuser;   // kind[1:0]
  logic        m_tlast;
  logic        cfg_wen;
  logic        cfg_index;
  logic [7:0]  cfg_data;

  glyph_run_strip_layout_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  typedef struct {
    cmd_t        cmd;
    logic [7:0]  code;
    logic [15:0] sx;
    logic [15:0] sy;
    int          reps;
    bit          typed;
    result_t     want;
  } step_row_t;

  // layout model state
  logic [8:0]  pen = '0;
  logic [15:0] origin_x = '0;
  logic [15:0] origin_y = '0;
  logic [6:0]  tally = '0;
  bit          sticky = 1'b0;
  logic [7:0]  slot_cfg = 8'd1;
  logic [7:0]  height_cfg = 8'd20;

  result_t results_due[$];

  int items_sent = 0;
  int burst_left = 0;
  int mismatches = 0;
  int results_checked = 0;
  int flushes_seen = 0;
  int faults_seen = 0;
  int cycle_count = 0;
  bit hold_request = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [3:0] advance_of(input logic [7:0] c);
    case (c)
      8'h20, 8'h2E, 8'h60: return 4'd5;
      8'h21, 8'h27, 8'h49, 8'h69, 8'h6C, 8'hA1: return 4'd4;
      8'h28, 8'h29, 8'h2F, 8'h3B, 8'h5B, 8'h5C,
      8'h5D, 8'h66, 8'h84, 8'h93, 8'h94: return 4'd8;
      8'h2C, 8'h6A, 8'h82, 8'h91, 8'h92, 8'hA6: return 4'd6;
      8'h3A, 8'h4A: return 4'd7;
      8'h4D, 8'h57, 8'h6D, 8'h77: return 4'd12;
      default: return 4'd9;
    endcase
  endfunction

  function automatic result_t error_report();
    result_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.error = 1'b1;
    return r;
  endfunction

  function automatic result_t take_flush();
    result_t r;
    r = '0;
    r.kind = KIND_FLUSH;
    r.slot_out = slot_cfg;
    r.pos_x = origin_x;
    r.pos_y = origin_y;
    r.u_end = {1'b0, pen} + 10'd1;
    r.v_end = 5'd20;
    r.run_width = pen;
    r.run_height = height_cfg;
    origin_x = origin_x + {7'd0, pen};
    pen = '0;
    tally = '0;
    return r;
  endfunction

  // returns the number of results queued for this request
  function automatic int lay_out_request(input cmd_t cmd, input logic [7:0] code,
                                         input logic [15:0] sx, input logic [15:0] sy);
    result_t made [2];
    result_t r;
    int n;
    logic [7:0] glyph;
    logic [3:0] adv;
    n = 0;
    if (cmd == CMD_BEGIN) begin
      origin_x = sx;
      origin_y = sy;
      pen = '0;
      tally = '0;
      sticky = 1'b0;
      return 0;
    end
    if (cmd == CMD_NONE) return 0;
    if (sticky) begin
      made[n++] = error_report();
    end else if (cmd == CMD_END) begin
      made[n++] = take_flush();
    end else if (tally >= MAX_UPLOADS) begin
      sticky = 1'b1;
      made[n++] = error_report();
    end else begin
      glyph = '0;
      adv = '0;
      if (code >= 8'h20) begin
        adv = advance_of(code);
        glyph = (code == 8'h24) ? 8'h89 : code - 8'h20;
      end
      r = '0;
      r.kind = KIND_UPLOAD;
      r.cell_x = pen;
      r.font_offset = glyph * 13'd30;
      made[n++] = r;
      tally = tally + 7'd1;
      pen = pen + {5'd0, adv};
      if (pen >= STRIP_WIDTH) made[n++] = take_flush();
    end
    made[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) results_due.push_back(made[i]);
    return n;
  endfunction

  task automatic send_request(input cmd_t cmd, input logic [7:0] code,
                              input logic [15:0] sx, input logic [15:0] sy,
                              output int made);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {sy, sx, code};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    made = lay_out_request(cmd, code, sx, sy);
    items_sent++;
    burst_left--;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [7:0] value);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    if (idx == REG_SLOT_NUMBER) slot_cfg = value;
    else height_cfg = value;
    cfg_wen <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_sequence();
    int sel;
    int n;
    int made;
    logic [7:0] code;
    sel = $urandom_range(0, 9);
    if (sel >= 8) begin
      // noise: anything, in any order
      n = $urandom_range(1, 4);
      repeat (n) send_request(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              16'($urandom), 16'($urandom), made);
      return;
    end
    send_request(CMD_BEGIN, 8'($urandom_range(0, 255)), 16'($urandom), 16'($urandom), made);
    if (sel == 7) begin
      // overflow: zero-advance bytes fill the upload budget without a flush
      repeat (MAX_UPLOADS) send_request(CMD_GLYPH, 8'($urandom_range(0, 31)),
                                        16'($urandom), 16'($urandom), made);
      n = $urandom_range(1, 3);
    end else if (sel >= 5) begin
      n = $urandom_range(30, 70);
    end else begin
      n = $urandom_range(1, 40);
    end
    repeat (n) begin
      code = 8'($urandom_range(0, 255));
      send_request(CMD_GLYPH, code, 16'($urandom), 16'($urandom), made);
    end
    if ($urandom_range(0, 4) != 0)
      send_request(CMD_END, 8'($urandom_range(0, 255)), 16'($urandom), 16'($urandom), made);
  endtask

  function automatic result_t up_res(input logic [8:0] strip_pos, input logic [12:0] offs);
    result_t r;
    r = '0;
    r.kind = KIND_UPLOAD;
    r.cell_x = strip_pos;
    r.font_offset = offs;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic result_t err_res();
    result_t r;
    r = error_report();
    r.last = 1'b1;
    return r;
  endfunction

  function automatic step_row_t mk_row(input cmd_t cmd, input logic [7:0] code,
                                       input logic [15:0] sx, input logic [15:0] sy,
                                       input int reps, input bit typed, input result_t want);
    step_row_t s;
    s.cmd = cmd;
    s.code = code;
    s.sx = sx;
    s.sy = sy;
    s.reps = reps;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  function automatic string fmt_result(input result_t r);
    return {$sformatf("kind=%0d cell_x=%0d offs=%0d slot=%0d pos=%0d,%0d",
                      r.kind, r.cell_x, r.font_offset, r.slot_out, r.pos_x, r.pos_y),
            $sformatf(" u=%0d v=%0d w=%0d h=%0d err=%0d last=%0d",
                      r.u_end, r.v_end, r.run_width, r.run_height, r.error, r.last)};
  endfunction

  function automatic string field_diff(input result_t a, input result_t b, input logic pad);
    string s;
    s = "";
    if (a.kind !== b.kind) s = {s, " kind"};
    if (a.cell_x !== b.cell_x) s = {s, " cell_x"};
    if (a.font_offset !== b.font_offset) s = {s, " font_offset"};
    if (a.slot_out !== b.slot_out) s = {s, " slot_out"};
    if (a.pos_x !== b.pos_x) s = {s, " pos_x"};
    if (a.pos_y !== b.pos_y) s = {s, " pos_y"};
    if (a.u_end !== b.u_end) s = {s, " u_end"};
    if (a.v_end !== b.v_end) s = {s, " v_end"};
    if (a.run_width !== b.run_width) s = {s, " run_width"};
    if (a.run_height !== b.run_height) s = {s, " run_height"};
    if (a.error !== b.error) s = {s, " error"};
    if (a.last !== b.last) s = {s, " last"};
    if (pad !== 1'b0) s = {s, " pad"};
    return s;
  endfunction

  task automatic note_mismatch(input string what, input result_t want, input result_t got,
                               input bit have_want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %0d at cycle %0d:%s", mismatches, cycle_count, what);
      if (have_want) $display("  expected %s", fmt_result(want));
      $display("  actual   %s", fmt_result(got));
    end
  endtask

  // result consumer: changing stall patterns plus an on-demand long hold-off
  initial begin
    int mode;
    int mode_left;
    int held;
    mode = 0;
    mode_left = 0;
    held = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        held = 300;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      if (held > 0) begin
        held--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(0, 1));
          2: m_tready <= (mode_left % 4) != 0;
          default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // result checker
  initial begin
    result_t got;
    result_t want;
    string bad;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        got.kind = kind_t'(m_tuser);
        got.cell_x = m_tdata[8:0];
        got.font_offset = m_tdata[21:9];
        got.slot_out = m_tdata[29:22];
        got.pos_x = m_tdata[45:30];
        got.pos_y = m_tdata[61:46];
        got.u_end = m_tdata[71:62];
        got.v_end = m_tdata[76:72];
        got.run_width = m_tdata[85:77];
        got.run_height = m_tdata[93:86];
        got.error = m_tdata[94];
        got.last = m_tlast;
        results_checked++;
        if (got.kind == KIND_FLUSH) flushes_seen++;
        if (got.kind == KIND_ERROR) faults_seen++;
        if (results_due.size() == 0) begin
          note_mismatch(" result with nothing pending", got, got, 1'b0);
        end else begin
          want = results_due.pop_front();
          bad = field_diff(want, got, m_tdata[95]);
          if (bad != "") note_mismatch(bad, want, got, 1'b1);
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still pending", cycle_count,
             results_due.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    step_row_t plan[$];
    int made;
    int directed_items;
    int target;
    result_t f0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= CMD_NONE;
    cfg_wen <= 1'b0;
    cfg_index <= REG_SLOT_NUMBER;
    cfg_data <= '0;

    f0 = '0;
    f0.kind = KIND_FLUSH;
    f0.slot_out = 8'd1;
    f0.u_end = 10'd1;
    f0.v_end = 5'd20;
    f0.run_height = 8'd20;
    f0.last = 1'b1;

    plan.push_back(mk_row(CMD_END,   8'h00, 16'h0000, 16'h0000, 1, 1'b1, f0));
    plan.push_back(mk_row(CMD_BEGIN, 8'h00, 16'hFFFF, 16'hFFFF, 1, 1'b0, '0));
    plan.push_back(mk_row(CMD_GLYPH, 8'h00, 16'h0000, 16'h0000, 1, 1'b1,
                          up_res(9'd0, 13'd0)));
    plan.push_back(mk_row(CMD_GLYPH, 8'h01, 16'h0000, 16'h0000, 1, 1'b1,
                          up_res(9'd0, 13'd0)));
    plan.push_back(mk_row(CMD_GLYPH, 8'h1F, 16'h0000, 16'h0000, 1, 1'b1,
                          up_res(9'd0, 13'd0)));
    plan.push_back(mk_row(CMD_GLYPH, 8'h24, 16'h0000, 16'h0000, 1, 1'b1,
                          up_res(9'd0, 13'd4110)));
    plan.push_back(mk_row(CMD_GLYPH, 8'hFF, 16'h0000, 16'h0000, 1, 1'b1,
                          up_res(9'd9, 13'd6690)));
    plan.push_back(mk_row(CMD_GLYPH, 8'h20, 16'h0000, 16'h0000, 1, 1'b1,
                          up_res(9'd18, 13'd0)));
    plan.push_back(mk_row(CMD_GLYPH, 8'h4D, 16'h0000, 16'h0000, 1, 1'b0, '0));
    plan.push_back(mk_row(CMD_NONE,  8'hFF, 16'hFFFF, 16'hFFFF, 1, 1'b0, '0));
    // end of run at the top of x: screen x wraps
    plan.push_back(mk_row(CMD_END,   8'hFF, 16'h0000, 16'h0000, 1, 1'b0, '0));
    plan.push_back(mk_row(CMD_BEGIN, 8'h00, 16'h0000, 16'h0000, 1, 1'b0, '0));
    // wide glyphs until the strip flushes on its own
    plan.push_back(mk_row(CMD_GLYPH, 8'h57, 16'h0000, 16'h0000, 22, 1'b0, '0));
    plan.push_back(mk_row(CMD_GLYPH, 8'h41, 16'h0000, 16'h0000, 1, 1'b0, '0));
    plan.push_back(mk_row(CMD_BEGIN, 8'h00, 16'h1234, 16'h5678, 1, 1'b0, '0));
    // fill the upload budget, then overflow and sticky fault
    plan.push_back(mk_row(CMD_GLYPH, 8'h01, 16'h0000, 16'h0000, 64, 1'b0, '0));
    plan.push_back(mk_row(CMD_GLYPH, 8'h41, 16'h0000, 16'h0000, 1, 1'b1, err_res()));
    plan.push_back(mk_row(CMD_GLYPH, 8'h41, 16'h0000, 16'h0000, 1, 1'b1, err_res()));
    plan.push_back(mk_row(CMD_END,   8'h00, 16'h0000, 16'h0000, 1, 1'b1, err_res()));
    plan.push_back(mk_row(CMD_NONE,  8'h00, 16'h0000, 16'h0000, 1, 1'b0, '0));
    plan.push_back(mk_row(CMD_BEGIN, 8'h00, 16'h0000, 16'h0000, 1, 1'b0, '0));
    plan.push_back(mk_row(CMD_GLYPH, 8'h41, 16'h0000, 16'h0000, 1, 1'b1,
                          up_res(9'd0, 13'd990)));
    plan.push_back(mk_row(CMD_END,   8'h00, 16'h0000, 16'h0000, 1, 1'b0, '0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        send_request(plan[i].cmd, plan[i].code, plan[i].sx, plan[i].sy, made);
        if (plan[i].typed && made == 1) results_due[results_due.size() - 1] = plan[i].want;
      end
    end
    directed_items = items_sent;
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_SLOT_NUMBER, 8'h00);
          write_reg(REG_HEIGHT_STEP, 8'h00);
        end
        1: begin
          write_reg(REG_SLOT_NUMBER, 8'hFF);
          write_reg(REG_HEIGHT_STEP, 8'hFF);
        end
        default: begin
          write_reg(REG_SLOT_NUMBER, 8'($urandom_range(0, 255)));
          write_reg(REG_HEIGHT_STEP, 8'($urandom_range(0, 255)));
        end
      endcase
      if (phase == 1) begin
        // consumer holds off while requests keep coming, so the unit backs up
        hold_request = 1'b1;
        burst_left = 48;
      end
      target = items_sent + 15;
      while (items_sent < target) run_sequence();
      drain();
    end

    $display("covered %0d requests (%0d directed) under 5 slot/height settings", items_sent,
             directed_items);
    $display("checked %0d results: %0d flushes, %0d overflow reports", results_checked,
             flushes_seen, faults_seen);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/grsl_pkg.sv
hw/rtl/grsl_core.sv
hw/rtl/glyph_run_strip_layout_unit.sv
bench/testbench.sv
